### src/connection_timeout_wheel_core_macros.svh
// Assertion macros shared by the connection timeout wheel RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CONNECTION_TIMEOUT_WHEEL_CORE_MACROS_SVH
`define CONNECTION_TIMEOUT_WHEEL_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CTW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CTW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ctw_pkg.sv
// Package for the connection timeout wheel: operation codes, controller states,
// field widths and parameter defaults. Depends on nothing.
`default_nettype none

package ctw_pkg;

    localparam int OP_W         = 2;
    localparam int ID_W         = 6;
    localparam int SLOT_COUNT_W = 7;

    localparam int DEF_MAX_CONNS = 64;
    localparam int DEF_MAX_SLOTS = 64;

    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 7'd64;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_REFRESH = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### src/ctw_cell.sv
// One cell of the entry ring: a valid bit and a slot number, shifted on to the
// neighbor cell whenever the ring moves. Depends on nothing.
`default_nettype none

module ctw_cell #(
    parameter int SLOT_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift,
    input  wire logic              d_valid,
    input  wire logic [SLOT_W-1:0] d_slot,
    output logic                   q_valid,
    output logic      [SLOT_W-1:0] q_slot
);

    logic              valid_reg;
    logic [SLOT_W-1:0] slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            slot_reg <= d_slot;
        end
    end

    assign q_valid = valid_reg;
    assign q_slot  = slot_reg;

endmodule

`default_nettype wire

### src/ctw_ctrl.sv
// Controller of the timeout wheel: slot count register, pointer, remainder unit,
// ring sequencing, head cell update and output register. Uses ctw_pkg and macros.
`default_nettype none
`include "connection_timeout_wheel_core_macros.svh"

module ctw_ctrl
    import ctw_pkg::*;
#(
    parameter int MAX_CONNS = DEF_MAX_CONNS,
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int PTR_W     = $clog2(MAX_SLOTS)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [SLOT_COUNT_W-1:0] cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [OP_W-1:0]         op,
    input  wire logic [ID_W-1:0]         conn_id,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic      [OP_W-1:0]         kind,
    output logic      [ID_W-1:0]         conn_id_res,
    output logic                         found,
    output logic                         expired,
    output logic                         last,
    output logic                         ring_shift,
    input  wire logic                    head_valid,
    input  wire logic [PTR_W-1:0]        head_slot,
    output logic                         tail_valid,
    output logic      [PTR_W-1:0]        tail_slot
);

    localparam int IDX_W  = $clog2(MAX_CONNS);
    localparam int NW     = PTR_W + 1;
    localparam int CW     = (SLOT_COUNT_W > NW) ? SLOT_COUNT_W : NW;
    localparam int STEP_W = $clog2(NW + 1);

    state_t                  state_reg, state_next;
    logic [SLOT_COUNT_W-1:0] slot_count_reg, slot_count_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic [NW-1:0]           n_reg, n_next;
    logic [NW-1:0]           x_reg, x_next;
    logic [NW-1:0]           rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [PTR_W-1:0]        target_reg, target_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic                    was_reg, was_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]        pend_id_reg, pend_id_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OP_W-1:0]         kind_reg, kind_next;
    logic [ID_W-1:0]         id_res_reg, id_res_next;
    logic                    found_reg, found_next;
    logic                    expired_reg, expired_next;
    logic                    last_reg, last_next;

    logic [CW-1:0] cfg_ext;
    logic [CW-1:0] n_wide;
    logic [NW-1:0] n_cur;
    logic [NW-1:0] ptr_ext;
    logic [NW-1:0] x_in;
    logic [NW-1:0] r_shift;
    logic [NW-1:0] r_new;
    logic          at_id;
    logic          hit;
    logic          need_emit;
    logic          out_free;
    logic          stall;
    logic          out_load;

    always_comb
    begin
        cfg_ext = CW'(slot_count_reg);
        if (slot_count_reg == '0)
        begin
            n_wide = CW'(1);
        end
        else if (cfg_ext > CW'(MAX_SLOTS))
        begin
            n_wide = CW'(MAX_SLOTS);
        end
        else
        begin
            n_wide = cfg_ext;
        end
        n_cur   = n_wide[NW-1:0];
        ptr_ext = NW'(ptr_reg);
        if (op == OP_TICK)
        begin
            x_in = (ptr_reg == '0) ? (n_cur - NW'(1)) : (ptr_ext - NW'(1));
        end
        else
        begin
            x_in = ptr_ext + NW'(1);
        end
        r_shift = {rem_reg[PTR_W-1:0], x_reg[NW-1]};
        r_new   = (r_shift >= n_reg) ? (r_shift - n_reg) : r_shift;
    end

    always_comb
    begin
        at_id      = (id_reg == ID_W'(cnt_reg));
        hit        = head_valid && (head_slot == ptr_reg);
        out_free   = !out_valid_reg || out_ready;
        tail_valid = head_valid;
        tail_slot  = head_slot;
        need_emit  = 1'b0;
        case (op_reg)
            OP_TICK:
            begin
                if (hit)
                begin
                    tail_valid = 1'b0;
                    need_emit  = pend_valid_reg;
                end
            end
            OP_ADD:
            begin
                if (at_id && !head_valid)
                begin
                    tail_valid = 1'b1;
                    tail_slot  = target_reg;
                end
            end
            OP_REMOVE:
            begin
                if (at_id)
                begin
                    tail_valid = 1'b0;
                end
            end
            OP_REFRESH:
            begin
                if (at_id && head_valid)
                begin
                    tail_slot = target_reg;
                end
            end
            default:
            begin
                tail_valid = head_valid;
            end
        endcase
        stall      = need_emit && !out_free;
        ring_shift = (state_reg == ST_SCAN) && !stall;
    end

    always_comb
    begin
        state_next      = state_reg;
        slot_count_next = cfg_we ? cfg_data : slot_count_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        n_next          = n_reg;
        x_next          = x_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        target_next     = target_reg;
        cnt_next        = cnt_reg;
        was_next        = was_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        id_res_next     = id_res_reg;
        found_next      = found_reg;
        expired_next    = expired_reg;
        last_next       = last_reg;
        in_ready        = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next         = op;
                    id_next         = conn_id;
                    n_next          = n_cur;
                    was_next        = 1'b0;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    if (x_in < n_cur)
                    begin
                        target_next = x_in[PTR_W-1:0];
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        x_next     = x_in;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                rem_next  = r_new;
                x_next    = x_reg << 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NW - 1))
                begin
                    target_next = r_new[PTR_W-1:0];
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (need_emit)
                    begin
                        out_load       = 1'b1;
                        out_valid_next = 1'b1;
                        kind_next      = OP_TICK;
                        id_res_next    = ID_W'(pend_id_reg);
                        found_next     = 1'b0;
                        expired_next   = 1'b1;
                        last_next      = 1'b0;
                    end
                    if (at_id)
                    begin
                        was_next = head_valid;
                    end
                    if ((op_reg == OP_TICK) && hit)
                    begin
                        pend_valid_next = 1'b1;
                        pend_id_next    = cnt_reg;
                    end
                    cnt_next = cnt_reg + IDX_W'(1);
                    if (cnt_reg == IDX_W'(MAX_CONNS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = op_reg;
                    last_next      = 1'b1;
                    if (op_reg == OP_TICK)
                    begin
                        id_res_next  = pend_valid_reg ? ID_W'(pend_id_reg) : '0;
                        found_next   = 1'b0;
                        expired_next = pend_valid_reg;
                        ptr_next     = target_reg;
                    end
                    else
                    begin
                        id_res_next  = id_reg;
                        found_next   = was_reg;
                        expired_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_count_reg <= SLOT_COUNT_RST;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_count_reg <= slot_count_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        n_reg       <= n_next;
        x_reg       <= x_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        target_reg  <= target_next;
        cnt_reg     <= cnt_next;
        was_reg     <= was_next;
        pend_id_reg <= pend_id_next;
        kind_reg    <= kind_next;
        id_res_reg  <= id_res_next;
        found_reg   <= found_next;
        expired_reg <= expired_next;
        last_reg    <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign conn_id_res = id_res_reg;
    assign found       = found_reg;
    assign expired     = expired_reg;
    assign last        = last_reg;

    // A result must never overwrite one that the receiver has not yet taken.
    `CTW_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_load, (!out_valid_reg || out_ready), "result overwritten")
    // The ring only moves during the scan.
    `CTW_ASSERT_IMP(a_shift_in_scan, clk, rst_n, ring_shift, (state_reg == ST_SCAN), "ring moved outside scan")
    // The new slot is always reduced below the slot count.
    `CTW_ASSERT_IMP(a_target_range, clk, rst_n, (state_reg == ST_SCAN), (NW'(target_reg) < n_reg), "slot out of range")
    // The pointer moves only when an item completes.
    `CTW_ASSERT_NXT(a_ptr_hold, clk, rst_n, (state_reg != ST_DONE), $stable(ptr_reg), "pointer moved early")

endmodule

`default_nettype wire

### src/connection_timeout_wheel_core.sv
// Connection timeout wheel: a ring of MAX_CONNS cells holding one entry per
// connection, rotated past a controller. Uses ctw_pkg, ctw_cell and ctw_ctrl.
//
// Usage: an item on the in channel (op, conn_id) is taken when in_valid and
// in_ready are both high. Add, remove and refresh give one result; a tick gives
// one result per expired connection in ascending id order, or a single result
// with expired low when the current slot is empty. The result item that ends
// an input item carries last high. The user must write slot_count through
// cfg_we and cfg_data only while the block is idle; the block does not enforce it.
// Timing: on acceptance the entry ring makes one full rotation, one cell per
// cycle while no stall holds it, past the head, where each connection's entry
// is read and rewritten in turn. The final result is then loaded into the
// output register and the block returns to idle, so a new item is taken only
// after the last one is through. When the new slot needs a wrap or the pointer
// lies beyond the slots in use, a bit-serial remainder unit runs before the
// rotation. in_ready is high only between items. A stalled receiver holds the
// current result in the output register; a tick that finds another expired
// connection then pauses the ring until that result is taken. Reset clears
// every entry, the pointer, and sets slot_count to 64.
`default_nettype none

module connection_timeout_wheel_core
    import ctw_pkg::*;
#(
    parameter int MAX_CONNS = DEF_MAX_CONNS,
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [SLOT_COUNT_W-1:0] cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [OP_W-1:0]         op,
    input  wire logic [ID_W-1:0]         conn_id,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic      [OP_W-1:0]         kind,
    output logic      [ID_W-1:0]         conn_id_res,
    output logic                         found,
    output logic                         expired,
    output logic                         last
);

    localparam int PTR_W = $clog2(MAX_SLOTS);

    logic             ring_shift;
    logic             tail_valid;
    logic [PTR_W-1:0] tail_slot;
    logic             cell_valid [MAX_CONNS];
    logic [PTR_W-1:0] cell_slot  [MAX_CONNS];

    genvar i;
    generate
        for (i = 0; i < MAX_CONNS; i++)
        begin : g_cell
            if (i == MAX_CONNS - 1)
            begin : g_tail
                ctw_cell #(
                    .SLOT_W (PTR_W)
                ) u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (ring_shift),
                    .d_valid (tail_valid),
                    .d_slot  (tail_slot),
                    .q_valid (cell_valid[i]),
                    .q_slot  (cell_slot[i])
                );
            end
            else
            begin : g_body
                ctw_cell #(
                    .SLOT_W (PTR_W)
                ) u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (ring_shift),
                    .d_valid (cell_valid[i+1]),
                    .d_slot  (cell_slot[i+1]),
                    .q_valid (cell_valid[i]),
                    .q_slot  (cell_slot[i])
                );
            end
        end
    endgenerate

    ctw_ctrl #(
        .MAX_CONNS (MAX_CONNS),
        .MAX_SLOTS (MAX_SLOTS),
        .PTR_W     (PTR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .conn_id     (conn_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .conn_id_res (conn_id_res),
        .found       (found),
        .expired     (expired),
        .last        (last),
        .ring_shift  (ring_shift),
        .head_valid  (cell_valid[0]),
        .head_slot   (cell_slot[0]),
        .tail_valid  (tail_valid),
        .tail_slot   (tail_slot)
    );

endmodule

`default_nettype wire

### dv/connection_timeout_wheel_core_tb.sv
// Self-checking testbench for connection_timeout_wheel_core: a directed table
// and random phases are checked against a timing wheel predictor.
// Depends on ctw_pkg and the connection_timeout_wheel_core RTL.
`default_nettype none

module connection_timeout_wheel_core_tb;
    import ctw_pkg::*;

    localparam int NUM_CONNS       = DEF_MAX_CONNS;
    localparam int NUM_SLOTS       = DEF_MAX_SLOTS;
    localparam int DIRECTED_ROWS   = 27;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 40;
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 100;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct packed {
        logic [OP_W-1:0] kind;
        logic [ID_W-1:0] id;
        logic            found;
        logic            expired;
        logic            last;
    } wheel_result_t;

    typedef struct packed {
        logic                    is_cfg;
        logic [SLOT_COUNT_W-1:0] cfg_value;
        logic [OP_W-1:0]         op;
        logic [ID_W-1:0]         id;
        logic                    typed;
        logic                    found;
    } directed_row_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE,
        READY_BURSTY
    } ready_mode_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [SLOT_COUNT_W-1:0] cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [OP_W-1:0]         op;
    logic [ID_W-1:0]         conn_id;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [OP_W-1:0]         kind;
    logic [ID_W-1:0]         conn_id_res;
    logic                    found;
    logic                    expired;
    logic                    last;

    logic                    model_valid [NUM_CONNS];
    int                      model_slot [NUM_CONNS];
    int                      model_ptr;
    logic [SLOT_COUNT_W-1:0] model_slot_count;

    wheel_result_t           step_results [$];
    wheel_result_t           pending_results [$];
    directed_row_t           dir_rows [DIRECTED_ROWS];

    int                      errors = 0;
    int                      items_sent = 0;
    int                      results_checked = 0;
    int                      expirations = 0;
    int                      longest_tick = 0;
    int                      cfg_writes = 0;
    int                      idle_gap = 0;
    int                      burst_left = 0;
    int                      quiet_cycles = 0;
    int unsigned             cycle_count = 0;
    ready_mode_t             ready_mode = READY_ALWAYS;

    connection_timeout_wheel_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .conn_id     (conn_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .conn_id_res (conn_id_res),
        .found       (found),
        .expired     (expired),
        .last        (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void wheel_clear();
        for (int i = 0; i < NUM_CONNS; i++)
        begin
            model_valid[i] = 1'b0;
            model_slot[i]  = 0;
        end
        model_ptr        = 0;
        model_slot_count = SLOT_COUNT_RST;
    endfunction

    function automatic void wheel_step(input logic [OP_W-1:0] op_i, input logic [ID_W-1:0] id_i);
        int            n;
        int            next_slot;
        logic          was;
        wheel_result_t r;
        step_results.delete();
        n = (model_slot_count == 0) ? 1 :
            (model_slot_count > NUM_SLOTS) ? NUM_SLOTS : int'(model_slot_count);
        next_slot = (model_ptr + 1) % n;
        was = model_valid[id_i];
        case (op_i)
            OP_ADD:
            begin
                if (!was)
                begin
                    model_valid[id_i] = 1'b1;
                    model_slot[id_i]  = next_slot;
                end
                step_results.push_back({OP_ADD, id_i, was, 1'b0, 1'b1});
            end
            OP_REMOVE:
            begin
                model_valid[id_i] = 1'b0;
                step_results.push_back({OP_REMOVE, id_i, was, 1'b0, 1'b1});
            end
            OP_REFRESH:
            begin
                if (was)
                    model_slot[id_i] = next_slot;
                step_results.push_back({OP_REFRESH, id_i, was, 1'b0, 1'b1});
            end
            default:
            begin
                for (int i = 0; i < NUM_CONNS; i++)
                begin
                    if (model_valid[i] && model_slot[i] == model_ptr)
                    begin
                        model_valid[i] = 1'b0;
                        step_results.push_back({OP_TICK, ID_W'(i), 1'b0, 1'b1, 1'b0});
                    end
                end
                if (step_results.size() == 0)
                    step_results.push_back({OP_TICK, ID_W'(0), 1'b0, 1'b0, 1'b1});
                else
                begin
                    r = step_results.pop_back();
                    r.last = 1'b1;
                    step_results.push_back(r);
                end
                if (step_results.size() > longest_tick)
                    longest_tick = step_results.size();
                model_ptr = (model_ptr == 0) ? n - 1 : (model_ptr - 1) % n;
            end
        endcase
    endfunction

    function automatic directed_row_t cfg_row(input logic [SLOT_COUNT_W-1:0] value);
        directed_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cfg_value = value;
        return row;
    endfunction

    function automatic directed_row_t op_row(input logic [OP_W-1:0] op_i,
                                             input logic [ID_W-1:0] id_i,
                                             input logic typed, input logic found_i);
        directed_row_t row;
        row = '0;
        row.op = op_i;
        row.id = id_i;
        row.typed = typed;
        row.found = found_i;
        return row;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op_i, input logic [ID_W-1:0] id_i,
                             input logic typed, input wheel_result_t typed_res);
        if (idle_gap > 0)
            repeat (idle_gap) @(posedge clk);
        in_valid <= 1'b1;
        op       <= op_i;
        conn_id  <= id_i;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        wheel_step(op_i, id_i);
        if (typed)
            pending_results.push_back(typed_res);
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
            idle_gap = 0;
        end
        else
        begin
            burst_left = $urandom_range(0, 10);
            idle_gap   = $urandom_range(0, 6);
        end
        if (idle_gap > 0)
            in_valid <= 1'b0;
    endtask

    task automatic drain_results(input int extra_cycles);
        if (idle_gap == 0)
            in_valid <= 1'b0;
        idle_gap = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (extra_cycles) @(posedge clk);
    endtask

    task automatic write_slot_count(input logic [SLOT_COUNT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        model_slot_count = value;
        cfg_writes++;
    endtask

    always @(posedge clk)
    begin
        wheel_result_t got;
        wheel_result_t want;
        cycle_count++;
        if (cycle_count % 256 == 0)
            ready_mode = ready_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: out_ready <= (cycle_count % 8 == 0);
            default:      out_ready <= (cycle_count % 16 >= 5);
        endcase
        if (rst_n && out_valid && out_ready)
        begin
            got = {kind, conn_id_res, found, expired, last};
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item %h, nothing expected", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.expired)
                    expirations++;
                if (got.kind !== want.kind)
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                if (got.id !== want.id)
                    $display("%0t: conn_id_res expected %0d actual %0d", $time, want.id, got.id);
                if (got.found !== want.found)
                    $display("%0t: found expected %b actual %b", $time, want.found, got.found);
                if (got.expired !== want.expired)
                    $display("%0t: expired expected %b actual %b", $time, want.expired,
                             got.expired);
                if (got.last !== want.last)
                    $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                if (got !== want)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        logic [OP_W-1:0] rand_op;
        logic [ID_W-1:0] rand_id;
        logic [ID_W-1:0] pool_base;
        logic [SLOT_COUNT_W-1:0] phase_count;
        int              pick;
        int              directed_items;

        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        op       = OP_ADD;
        conn_id  = '0;
        wheel_clear();

        dir_rows[0]  = op_row(OP_TICK, 0, 1'b1, 1'b0);
        dir_rows[1]  = op_row(OP_REMOVE, 63, 1'b1, 1'b0);
        dir_rows[2]  = op_row(OP_REFRESH, 0, 1'b1, 1'b0);
        dir_rows[3]  = op_row(OP_ADD, 0, 1'b1, 1'b0);
        dir_rows[4]  = op_row(OP_ADD, 0, 1'b1, 1'b1);
        dir_rows[5]  = op_row(OP_ADD, 63, 1'b1, 1'b0);
        dir_rows[6]  = op_row(OP_REFRESH, 63, 1'b1, 1'b1);
        dir_rows[7]  = op_row(OP_TICK, 0, 1'b1, 1'b0);
        dir_rows[8]  = cfg_row(1);
        dir_rows[9]  = op_row(OP_ADD, 5, 1'b0, 1'b0);
        dir_rows[10] = op_row(OP_TICK, 0, 1'b0, 1'b0);
        dir_rows[11] = op_row(OP_TICK, 0, 1'b0, 1'b0);
        dir_rows[12] = cfg_row(0);
        dir_rows[13] = op_row(OP_ADD, 10, 1'b0, 1'b0);
        dir_rows[14] = op_row(OP_ADD, 11, 1'b0, 1'b0);
        dir_rows[15] = op_row(OP_TICK, 0, 1'b0, 1'b0);
        dir_rows[16] = cfg_row(127);
        dir_rows[17] = op_row(OP_TICK, 0, 1'b0, 1'b0);
        dir_rows[18] = op_row(OP_ADD, 42, 1'b0, 1'b0);
        dir_rows[19] = op_row(OP_TICK, 0, 1'b0, 1'b0);
        dir_rows[20] = op_row(OP_ADD, 43, 1'b0, 1'b0);
        dir_rows[21] = cfg_row(2);
        dir_rows[22] = op_row(OP_REMOVE, 43, 1'b0, 1'b0);
        dir_rows[23] = op_row(OP_REFRESH, 42, 1'b0, 1'b0);
        dir_rows[24] = op_row(OP_TICK, 0, 1'b0, 1'b0);
        dir_rows[25] = op_row(OP_TICK, 0, 1'b0, 1'b0);
        dir_rows[26] = cfg_row(64);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                drain_results(SETTLE_CYCLES);
                write_slot_count(dir_rows[i].cfg_value);
            end
            else
                send_item(dir_rows[i].op, dir_rows[i].id, dir_rows[i].typed,
                          {dir_rows[i].op, dir_rows[i].id, dir_rows[i].found, 1'b0, 1'b1});
        end
        directed_items = items_sent;

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       phase_count = 1;
                1:       phase_count = 64;
                2:       phase_count = SLOT_COUNT_W'($urandom_range(2, 6));
                3:       phase_count = 0;
                4:       phase_count = 127;
                5:       phase_count = SLOT_COUNT_W'($urandom_range(1, 64));
                6:       phase_count = SLOT_COUNT_W'($urandom_range(65, 127));
                default: phase_count = SLOT_COUNT_W'($urandom_range(1, 4));
            endcase
            drain_results(SETTLE_CYCLES);
            write_slot_count(phase_count);
            pool_base = ID_W'($urandom_range(0, 63));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    rand_op = OP_ADD;
                else if (pick < 50)
                    rand_op = OP_REMOVE;
                else if (pick < 65)
                    rand_op = OP_REFRESH;
                else
                    rand_op = OP_TICK;
                if ($urandom_range(0, 1))
                    rand_id = pool_base + ID_W'($urandom_range(0, 7));
                else
                    rand_id = ID_W'($urandom_range(0, 63));
                send_item(rand_op, rand_id, 1'b0, '0);
            end
        end

        drain_results(END_CYCLES);

        $display("Run covered %0d items (%0d directed), %0d results checked, %0d expirations.",
                 items_sent, directed_items, results_checked, expirations);
        $display("Slot count was written %0d times; the largest tick gave %0d results.",
                 cfg_writes, longest_tick);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
